/* design/hdf_pkg.sv */
// Shared constants, types and character helpers of the hex dump formatter.
// No dependencies; hdf_ctrl, hdf_dp and the top level import it.
package hdf_pkg;

	// Line geometry
	localparam int HDF_MAX_COLS     = 32;
	localparam int HDF_DEFAULT_COLS = 16;
	localparam int HDF_CFG_W        = 6;
	localparam int HDF_CHARS        = 8;
	localparam int HDF_CNT_W        = 4;

	// ASCII codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_FIRST = 8'h20;
	localparam logic [7:0] CH_LAST  = 8'h7e;

	// Controller states, also the segment the datapath is producing
	typedef logic [2:0] hdf_state_t;
	localparam hdf_state_t ST_IDLE  = 3'd0;
	localparam hdf_state_t ST_HDR   = 3'd1;
	localparam hdf_state_t ST_HEX   = 3'd2;
	localparam hdf_state_t ST_PAD   = 3'd3;
	localparam hdf_state_t ST_SEP   = 3'd4;
	localparam hdf_state_t ST_ASC   = 3'd5;
	localparam hdf_state_t ST_NL    = 3'd6;
	localparam hdf_state_t ST_FLUSH = 3'd7;

	// Controller to datapath
	typedef struct packed {
		hdf_state_t phase;
		logic       take;
		logic       produce;
		logic       flush;
	} hdf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_fire;
		logic line_start;
		logic emit_fire;
		logic seg_last;
		logic close_line;
		logic pad_needed;
		logic xfer;
	} hdf_stat_t;

	// Lowercase hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'h0, nib};
		end else begin
			c = 8'h57 + {4'h0, nib};
		end
		return c;
	endfunction

	// Printable characters pass, others show as a dot
	function automatic logic [7:0] show_char(input logic [7:0] b);
		logic [7:0] c;
		if (b >= CH_FIRST && b <= CH_LAST) begin
			c = b;
		end else begin
			c = CH_DOT;
		end
		return c;
	endfunction

endpackage

/* design/hdf_if.sv */
// Valid/ready channel interfaces of the hex dump formatter: raw bytes in,
// packed text out. No dependencies.
interface hdf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source(output valid, data_byte, final_byte, input ready);
	modport sink(input valid, data_byte, final_byte, output ready);
endinterface

interface hdf_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_0;
	logic [7:0] char_1;
	logic [7:0] char_2;
	logic [7:0] char_3;
	logic [7:0] char_4;
	logic [7:0] char_5;
	logic [7:0] char_6;
	logic [7:0] char_7;
	logic [3:0] char_count;
	logic       end_of_run;

	modport source(output valid, char_0, char_1, char_2, char_3, char_4, char_5, char_6,
		char_7, char_count, end_of_run, input ready);
	modport sink(input valid, char_0, char_1, char_2, char_3, char_4, char_5, char_6,
		char_7, char_count, end_of_run, output ready);
endinterface

/* design/hdf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/hdf_ctrl.sv */
// Sequencer of the hex dump formatter: steps through the text segments of
// one item. Depends on hdf_pkg.
module hdf_ctrl
	import hdf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  hdf_stat_t stat,
	output hdf_cmd_t  cmd
);

	hdf_state_t state_q;
	hdf_state_t state_d;

	// Next segment
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.in_fire) begin
					state_d = stat.line_start ? ST_HDR : ST_HEX;
				end
			end
			ST_HDR: begin
				if (stat.emit_fire && stat.seg_last) begin
					state_d = ST_HEX;
				end
			end
			ST_HEX: begin
				if (stat.emit_fire && stat.seg_last) begin
					if (!stat.close_line) begin
						state_d = ST_FLUSH;
					end else if (stat.pad_needed) begin
						state_d = ST_PAD;
					end else begin
						state_d = ST_SEP;
					end
				end
			end
			ST_PAD: begin
				if (stat.emit_fire && stat.seg_last) begin
					state_d = ST_SEP;
				end
			end
			ST_SEP: begin
				if (stat.emit_fire) begin
					state_d = ST_ASC;
				end
			end
			ST_ASC: begin
				if (stat.emit_fire && stat.seg_last) begin
					state_d = ST_NL;
				end
			end
			ST_NL: begin
				if (stat.emit_fire) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (stat.xfer) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands
	always_comb begin
		cmd.phase   = state_q;
		cmd.take    = (state_q == ST_IDLE);
		cmd.produce = (state_q != ST_IDLE) && (state_q != ST_FLUSH);
		cmd.flush   = (state_q == ST_FLUSH);
	end

endmodule

/* design/hdf_dp.sv */
// Datapath of the hex dump formatter: offset, line store, character
// generation, 8-character packer and output register. Depends on hdf_pkg,
// hdf_if and hdf_ram.
module hdf_dp
	import hdf_pkg::*;
#(
	parameter int MAX_COLS = HDF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [HDF_CFG_W-1:0] cfg_wdata,
	input  hdf_cmd_t             cmd,
	output hdf_stat_t            stat,
	hdf_byte_if.sink             byte_ch,
	hdf_text_if.source           text_ch
);

	localparam int COL_W    = $clog2(MAX_COLS + 1);
	localparam int IDX_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DEF_COLS = (HDF_DEFAULT_COLS > MAX_COLS) ? MAX_COLS : HDF_DEFAULT_COLS;

	logic [HDF_CFG_W-1:0] cfg_q;
	logic [COL_W-1:0]     cols;
	logic [COL_W-1:0]     mid;
	logic [31:0]          offset_q;
	logic [COL_W-1:0]     fill_q;
	logic [COL_W-1:0]     pos;
	logic [COL_W-1:0]     pos_q;
	logic [7:0]           byte_q;
	logic                 close_q;
	logic [3:0]           sub_q;
	logic [COL_W-1:0]     col_q;
	logic [COL_W-1:0]     rd_col;
	logic [7:0]           rd_data;
	logic [31:0]          off_sh;
	logic                 in_fire;
	logic                 extra_hex;
	logic                 extra_pad;
	logic                 col_end;
	logic                 seg_last;
	logic [7:0]           ch;
	logic [7:0]           pack_q [HDF_CHARS];
	logic [HDF_CNT_W-1:0] pack_cnt_q;
	logic                 pack_full;
	logic                 out_free;
	logic                 xfer;
	logic                 emit_fire;
	logic                 out_valid_q;
	logic [7:0]           out_char_q [HDF_CHARS];
	logic [HDF_CNT_W-1:0] out_cnt_q;
	logic                 out_eor_q;

	// Width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= HDF_CFG_W'(HDF_DEFAULT_COLS);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Effective width: zero means default, limit to the line store
	always_comb begin
		if (cfg_q == '0) begin
			cols = COL_W'(DEF_COLS);
		end else if (int'(cfg_q) > MAX_COLS) begin
			cols = COL_W'(MAX_COLS);
		end else begin
			cols = COL_W'(cfg_q);
		end
		mid = cols >> 1;
	end

	// Column of the incoming byte, held at the last one if the line is full
	assign pos     = (int'(fill_q) >= MAX_COLS) ? COL_W'(MAX_COLS - 1) : fill_q;
	assign in_fire = byte_ch.valid && cmd.take;
	assign byte_ch.ready = cmd.take;

	// Latch the item
	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_q  <= byte_ch.data_byte;
			pos_q   <= pos;
			close_q <= byte_ch.final_byte || ((pos + COL_W'(1)) >= cols);
		end
	end

	// Line fill and stream offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			offset_q <= '0;
		end else begin
			if (in_fire) begin
				fill_q <= pos + COL_W'(1);
			end else if (emit_fire && cmd.phase == ST_NL) begin
				fill_q <= '0;
			end
			if (xfer && cmd.flush) begin
				offset_q <= offset_q + 32'd1;
			end
		end
	end

	// Line store: write on accept, read in order for the ASCII column
	assign rd_col = emit_fire ? (col_q + COL_W'(1)) : col_q;

	hdf_ram #(
		.WIDTH(8),
		.DEPTH(MAX_COLS)
	) u_line_ram (
		.clk  (clk),
		.we   (in_fire),
		.waddr(pos[IDX_W-1:0]),
		.wdata(byte_ch.data_byte),
		.raddr((cmd.phase == ST_ASC) ? rd_col[IDX_W-1:0] : IDX_W'(0)),
		.rdata(rd_data)
	);

	// Character of the current segment
	assign off_sh    = offset_q >> {~sub_q[2:0], 2'b00};
	assign extra_hex = (mid != '0) && ((pos_q + COL_W'(1)) == mid);
	assign extra_pad = (mid != '0) && ((col_q + COL_W'(1)) == mid);
	assign col_end   = ((sub_q == 4'd2) && !extra_pad) || (sub_q == 4'd3);

	always_comb begin
		ch       = CH_SPACE;
		seg_last = 1'b0;
		unique case (cmd.phase)
			ST_HDR: begin
				if (sub_q < 4'd8) begin
					ch = hex_char(off_sh[3:0]);
				end else if (sub_q == 4'd8) begin
					ch = CH_COLON;
				end
				seg_last = (sub_q == 4'd9);
			end
			ST_HEX: begin
				if (sub_q == 4'd0) begin
					ch = hex_char(byte_q[7:4]);
				end else if (sub_q == 4'd1) begin
					ch = hex_char(byte_q[3:0]);
				end
				seg_last = ((sub_q == 4'd2) && !extra_hex) || (sub_q == 4'd3);
			end
			ST_PAD: begin
				seg_last = col_end && (col_q == (cols - COL_W'(1)));
			end
			ST_SEP: begin
				seg_last = 1'b1;
			end
			ST_ASC: begin
				ch       = show_char(rd_data);
				seg_last = ((col_q + COL_W'(1)) == fill_q);
			end
			ST_NL: begin
				ch       = CH_NL;
				seg_last = 1'b1;
			end
			default: begin
				ch       = CH_SPACE;
				seg_last = 1'b0;
			end
		endcase
	end

	// Segment counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
			col_q <= '0;
		end else if (emit_fire) begin
			if (seg_last) begin
				sub_q <= '0;
				col_q <= (cmd.phase == ST_HEX) ? fill_q : '0;
			end else begin
				case (cmd.phase)
					ST_PAD: begin
						if (col_end) begin
							sub_q <= '0;
							col_q <= col_q + COL_W'(1);
						end else begin
							sub_q <= sub_q + 4'd1;
						end
					end
					ST_ASC: begin
						col_q <= col_q + COL_W'(1);
					end
					default: begin
						sub_q <= sub_q + 4'd1;
					end
				endcase
			end
		end
	end

	// Packer handshake: a full pack leaves only when more text follows,
	// the last one leaves on flush with end of run set
	assign pack_full = (pack_cnt_q == HDF_CNT_W'(HDF_CHARS));
	assign out_free  = !out_valid_q || text_ch.ready;
	assign xfer      = out_free && (cmd.flush || (cmd.produce && pack_full));
	assign emit_fire = cmd.produce && (!pack_full || xfer);

	// Collect characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_cnt_q <= '0;
		end else if (xfer) begin
			pack_cnt_q <= emit_fire ? HDF_CNT_W'(1) : '0;
		end else if (emit_fire) begin
			pack_cnt_q <= pack_cnt_q + HDF_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			if (xfer) begin
				pack_q[0] <= ch;
			end else begin
				pack_q[pack_cnt_q[2:0]] <= ch;
			end
		end
	end

	// Output register, unused characters zeroed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer) begin
			out_valid_q <= 1'b1;
		end else if (text_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			for (int i = 0; i < HDF_CHARS; i++) begin
				out_char_q[i] <= (HDF_CNT_W'(i) < pack_cnt_q) ? pack_q[i] : 8'h00;
			end
			out_cnt_q <= pack_cnt_q;
			out_eor_q <= cmd.flush;
		end
	end

	assign text_ch.valid      = out_valid_q;
	assign text_ch.char_0     = out_char_q[0];
	assign text_ch.char_1     = out_char_q[1];
	assign text_ch.char_2     = out_char_q[2];
	assign text_ch.char_3     = out_char_q[3];
	assign text_ch.char_4     = out_char_q[4];
	assign text_ch.char_5     = out_char_q[5];
	assign text_ch.char_6     = out_char_q[6];
	assign text_ch.char_7     = out_char_q[7];
	assign text_ch.char_count = out_cnt_q;
	assign text_ch.end_of_run = out_eor_q;

	// Status
	always_comb begin
		stat.in_fire    = in_fire;
		stat.line_start = (fill_q == '0);
		stat.emit_fire  = emit_fire;
		stat.seg_last   = seg_last;
		stat.close_line = close_q;
		stat.pad_needed = (fill_q < cols);
		stat.xfer       = xfer;
	end

endmodule

/* design/hex_dump_formatter_top.sv */
// Hex dump formatter: turns a byte stream into hex-dump text with an ASCII
// column, one item in and a run of up to eight characters per result out.
// Once an item is taken, the block makes one character per cycle into an
// 8-character packer unless the packer is full and the output stalls, then
// hands over the last result in the flush state. A byte gives its hex digits,
// preceded by the offset header at the start of a line; a byte that closes a
// line adds the padding, the separator, the ASCII characters and the newline.
// Input is refused while an item is being formatted. Depends on hdf_pkg,
// hdf_if, hdf_ctrl and hdf_dp.
module hex_dump_formatter_top
	import hdf_pkg::*;
#(
	parameter int MAX_COLS = HDF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [HDF_CFG_W-1:0] cfg_wdata,
	hdf_byte_if.sink             byte_ch,
	hdf_text_if.source           text_ch
);

	hdf_cmd_t  cmd;
	hdf_stat_t stat;

	// Segment sequencer
	hdf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.cmd   (cmd)
	);

	// Text datapath
	hdf_dp #(
		.MAX_COLS(MAX_COLS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.stat     (stat),
		.byte_ch  (byte_ch),
		.text_ch  (text_ch)
	);

endmodule

/* design/hdf_checker.sv */
// Port-level checks of the hex dump formatter and their bind to the top
// level. Depends on hex_dump_formatter_top and hdf_if.
module hdf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] char_count,
	input logic [7:0] char_7,
	input logic       end_of_run
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_count))
		else $error("result dropped or changed while stalled");

	// Count in range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_count != 4'd0) && (char_count <= 4'd8))
		else $error("character count out of range");

	// Only the last result of an item may be short
	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (char_count != 4'd8) |-> end_of_run)
		else $error("short result before end of run");

	// The last character slot reads zero in a short result
	a_zero_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (char_count != 4'd8) |-> (char_7 == 8'h00))
		else $error("unused character not zero");

	// Busy after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while formatting");

endmodule

bind hex_dump_formatter_top hdf_checker u_hdf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_ch.valid),
	.in_ready  (byte_ch.ready),
	.out_valid (text_ch.valid),
	.out_ready (text_ch.ready),
	.char_count(text_ch.char_count),
	.char_7    (text_ch.char_7),
	.end_of_run(text_ch.end_of_run)
);
